### rtl/ttlc_pkg.sv
// Package for the keyed TTL cache: function, status and register codes, sequencer states,
// entry type and signed key order. No dependencies.
`timescale 1ns / 1ps
package ttlc_pkg;
    typedef enum logic [1:0] {
        FN_INSERT = 2'd0,
        FN_LOOKUP = 2'd1,
        FN_CLEAR  = 2'd2,
        FN_NONE   = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_DISABLED = 2'd1,
        ST_FULL     = 2'd2
    } t_status;

    typedef enum logic [1:0] {
        REG_MAX_AGE = 2'd0,
        REG_BUDGET  = 2'd1
    } t_reg;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SWEEP_RD,
        S_SWEEP_CHK,
        S_CHECK,
        S_SEARCH,
        S_SEARCH_CHK,
        S_REMOVE,
        S_INSERT,
        S_INS_PUT,
        S_EVICT,
        S_FINISH
    } t_state;

    typedef struct packed {
        logic [63:0] key;
        logic [31:0] handle;
        logic [15:0] len;
        logic [47:0] stamp;
    } t_entry;

    function automatic logic key_less(input logic [63:0] a, input logic [63:0] b);
        return (a ^ 64'h8000_0000_0000_0000) < (b ^ 64'h8000_0000_0000_0000);
    endfunction
endpackage

### rtl/ttl_keyed_cache_with_sweep_unit.sv
// Top level of the keyed TTL cache: sequencer over a sorted entry memory.
// Depends on ttlc_pkg and ttlc_store.
//
// channel  | direction | handshake       | payload
// request  | in        | i_start/o_busy  | func, key, payload_handle, payload_len, now_ms
// result   | out       | o_done strobe   | hit, found_handle, found_len, status
// config   | in        | i_cfg_valid/rdy | index, data
//
// The sweep remove (also the budget eviction), the key search, a replace remove
// and the insert shift walk the entries one at a time, each entry being read
// before its check or write, since the entry memory has a single read port.
// Reset clears count, cursor and byte total and loads the registers with their defaults;
// memory needs no clear. The result strobe cannot be stalled; registers are written only while idle.
`timescale 1ns / 1ps
module ttl_keyed_cache_with_sweep_unit #(
    parameter int ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    output logic        o_busy,
    input  logic [1:0]  i_func,
    input  logic signed [63:0] i_key,
    input  logic [31:0] i_payload_handle,
    input  logic [15:0] i_payload_len,
    input  logic [47:0] i_now_ms,
    output logic        o_done,
    output logic        o_hit,
    output logic [31:0] o_found_handle,
    output logic [15:0] o_found_len,
    output logic [1:0]  o_status,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);
    import ttlc_pkg::*;
    localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CW = $clog2(ENTRIES + 1);

    t_state r_state, n_state;
    logic [31:0] r_max_age, r_budget;
    logic [CW-1:0] r_count, n_count, r_cursor, n_cursor, r_pos, n_pos, r_idx, n_idx;
    logic [31:0] r_bytes, n_bytes;
    t_func r_func;
    logic [63:0] r_key;
    logic [31:0] r_handle;
    logic [15:0] r_len;
    logic [47:0] r_now;
    logic r_forced, n_forced;
    logic r_hit, n_hit;
    logic [31:0] r_fh, n_fh;
    logic [15:0] r_fl, n_fl;
    logic [1:0] r_st, n_st;
    logic r_done, n_done;
    logic r_phase, n_phase;
    logic r_replace, n_replace;

    logic        we;
    logic [AW-1:0] waddr, raddr;
    t_entry      wdata, rdata;
    logic [63:0] exp_sum;

    ttlc_store #(.ENTRIES(ENTRIES), .AW(AW)) u_store (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign exp_sum = {16'd0, rdata.stamp} + {32'd0, r_max_age};
    assign o_busy = (r_state != S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE) && !i_start;
    assign o_done = r_done;
    assign o_hit = r_hit;
    assign o_found_handle = r_fh;
    assign o_found_len = r_fl;
    assign o_status = r_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_max_age <= 32'd1000;
            r_budget <= 32'd1000000;
            r_count <= '0;
            r_cursor <= '0;
            r_bytes <= '0;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_cursor <= n_cursor;
            r_bytes <= n_bytes;
            r_done <= n_done;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == REG_MAX_AGE) r_max_age <= i_cfg_data;
                else if (i_cfg_index == REG_BUDGET) r_budget <= i_cfg_data;
            end
        end
        r_pos <= n_pos;
        r_idx <= n_idx;
        r_forced <= n_forced;
        r_hit <= n_hit;
        r_fh <= n_fh;
        r_fl <= n_fl;
        r_st <= n_st;
        r_phase <= n_phase;
        r_replace <= n_replace;
        if (i_start && !o_busy) begin
            r_func <= t_func'(i_func);
            r_key <= i_key;
            r_handle <= i_payload_handle;
            r_len <= i_payload_len;
            r_now <= i_now_ms;
        end
    end

    // Next state, counters and memory controls.
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_cursor = r_cursor;
        n_bytes = r_bytes;
        n_pos = r_pos;
        n_idx = r_idx;
        n_forced = r_forced;
        n_hit = r_hit;
        n_fh = r_fh;
        n_fl = r_fl;
        n_st = r_st;
        n_done = 1'b0;
        n_phase = r_phase;
        n_replace = r_replace;
        we = 1'b0;
        waddr = r_idx[AW-1:0];
        wdata = rdata;
        raddr = r_idx[AW-1:0];
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_hit = 1'b0;
                    n_fh = '0;
                    n_fl = '0;
                    n_st = ST_DONE;
                    n_forced = 1'b0;
                    case (t_func'(i_func))
                        FN_INSERT, FN_LOOKUP: n_state = S_SWEEP_RD;
                        FN_CLEAR: begin
                            n_count = '0;
                            n_cursor = '0;
                            n_bytes = '0;
                            n_state = S_FINISH;
                        end
                        default: n_state = S_FINISH;
                    endcase
                end
            end
            S_SWEEP_RD: begin
                raddr = r_cursor[AW-1:0];
                if (r_cursor >= r_count) begin
                    n_cursor = '0;
                    n_state = r_forced ? S_FINISH : S_CHECK;
                end else begin
                    n_state = S_SWEEP_CHK;
                end
            end
            S_SWEEP_CHK: begin
                if (r_forced || exp_sum < {16'd0, r_now}) begin
                    n_bytes = r_bytes - {16'd0, rdata.len};
                    n_idx = r_cursor;
                    n_phase = 1'b0;
                    n_count = r_count - CW'(1);
                    n_state = S_REMOVE;
                    n_pos = r_count; // cursor stays; shift from cursor
                    n_replace = 1'b0;
                end else begin
                    n_cursor = r_cursor + CW'(1);
                    n_state = r_forced ? S_FINISH : S_CHECK;
                end
            end
            S_CHECK: begin
                if (r_func == FN_INSERT && (r_max_age == '0 || r_budget == '0)) begin
                    n_st = ST_DISABLED;
                    n_state = S_FINISH;
                end else begin
                    n_idx = '0;
                    n_state = S_SEARCH;
                end
            end
            S_SEARCH: begin
                raddr = r_idx[AW-1:0];
                if (r_idx >= r_count) begin
                    n_pos = r_idx;
                    n_state = S_INSERT;
                    n_phase = 1'b0;
                    if (r_func == FN_LOOKUP) n_state = S_FINISH;
                end else begin
                    n_state = S_SEARCH_CHK;
                end
            end
            S_SEARCH_CHK: begin
                if (key_less(rdata.key, r_key)) begin
                    n_idx = r_idx + CW'(1);
                    n_state = S_SEARCH;
                end else begin
                    n_pos = r_idx;
                    if (r_func == FN_LOOKUP) begin
                        if (rdata.key == r_key && exp_sum >= {16'd0, r_now}) begin
                            n_hit = 1'b1;
                            n_fh = rdata.handle;
                            n_fl = rdata.len;
                        end
                        n_state = S_FINISH;
                    end else if (rdata.key == r_key) begin
                        n_bytes = r_bytes - {16'd0, rdata.len};
                        n_count = r_count - CW'(1);
                        if (r_cursor > r_idx) n_cursor = r_cursor - CW'(1);
                        n_phase = 1'b0;
                        n_replace = 1'b1; // insert follows the remove
                        n_state = S_REMOVE;
                    end else begin
                        n_phase = 1'b0;
                        n_idx = r_count;
                        n_state = S_INSERT;
                    end
                end
            end
            S_REMOVE: begin
                // shift entries above r_idx down by one; r_count already reduced
                if (r_idx >= r_count) begin
                    if (r_replace) begin
                        n_idx = r_count;
                        n_phase = 1'b0;
                        n_state = S_INSERT;
                    end else begin
                        n_state = r_forced ? S_FINISH : S_CHECK;
                    end
                end else if (!r_phase) begin
                    raddr = AW'(r_idx + CW'(1));
                    n_phase = 1'b1;
                end else begin
                    we = 1'b1;
                    n_idx = r_idx + CW'(1);
                    n_phase = 1'b0;
                end
            end
            S_INSERT: begin
                if (r_phase == 1'b0 && r_idx == r_count && r_count >= CW'(ENTRIES)) begin
                    n_st = ST_FULL;
                    n_state = S_FINISH;
                end else if (r_idx == r_pos) begin
                    n_state = S_INS_PUT;
                end else if (!r_phase) begin
                    raddr = AW'(r_idx - CW'(1));
                    n_phase = 1'b1;
                end else begin
                    we = 1'b1;
                    n_idx = r_idx - CW'(1);
                    n_phase = 1'b0;
                end
            end
            S_INS_PUT: begin
                we = 1'b1;
                waddr = r_pos[AW-1:0];
                wdata.key = r_key;
                wdata.handle = r_handle;
                wdata.len = r_len;
                wdata.stamp = r_now;
                n_count = r_count + CW'(1);
                if (r_cursor >= r_pos) n_cursor = r_cursor + CW'(1);
                n_bytes = r_bytes + {16'd0, r_len};
                n_state = S_EVICT;
            end
            S_EVICT: begin
                if (r_bytes > r_budget) begin
                    n_forced = 1'b1;
                    n_state = S_SWEEP_RD;
                end else begin
                    n_state = S_FINISH;
                end
            end
            S_FINISH: begin
                n_done = 1'b1;
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end
endmodule

### rtl/ttlc_store.sv
// Entry memory of the keyed TTL cache: one write port, one registered read port.
// Depends on ttlc_pkg.
`timescale 1ns / 1ps
module ttlc_store #(
    parameter int ENTRIES = 256,
    parameter int AW = 8
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  ttlc_pkg::t_entry i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output ttlc_pkg::t_entry o_rdata
);
    import ttlc_pkg::*;
    t_entry r_mem [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

### rtl/ttlc_checker.sv
// Port-level assertions for the keyed TTL cache, bound to the top level.
// Depends on ttlc_pkg and ttl_keyed_cache_with_sweep_unit.
`timescale 1ns / 1ps
module ttlc_port_props (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_start,
    input logic        o_busy,
    input logic        o_done,
    input logic        o_hit,
    input logic [31:0] o_found_handle,
    input logic [1:0]  o_status
);
    import ttlc_pkg::*;

    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> o_busy) else $error("request not taken");
    a_done_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> !o_busy) else $error("strobe while busy");
    a_done_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> !o_done) else $error("double strobe");
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && !o_hit) |-> (o_found_handle == 32'd0)) else $error("miss data");
    a_hit_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && o_hit) |-> (o_status == ST_DONE)) else $error("hit status");
endmodule

bind ttl_keyed_cache_with_sweep_unit ttlc_port_props u_port_props (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start), .o_busy(o_busy),
    .o_done(o_done), .o_hit(o_hit), .o_found_handle(o_found_handle),
    .o_status(o_status)
);

### bench/ttlc_checker.sv
// Checker for the keyed TTL cache: watches request, result and register channels,
// predicts each result from its own table copy and compares field by field.
// Depends on ttlc_pkg.
`timescale 1ns / 1ps
module ttlc_checker #(
    parameter int ENTRIES = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_start,
    input  logic        i_busy,
    input  logic [1:0]  i_func,
    input  logic [63:0] i_key,
    input  logic [31:0] i_handle,
    input  logic [15:0] i_len,
    input  logic [47:0] i_now,
    input  logic        i_done,
    input  logic        i_hit,
    input  logic [31:0] i_found_handle,
    input  logic [15:0] i_found_len,
    input  logic [1:0]  i_status,
    input  logic        i_cfg_valid,
    input  logic        i_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output int          o_fail_count,
    output int          o_pending
);
    import ttlc_pkg::*;

    typedef struct {
        logic        hit;
        logic [31:0] handle;
        logic [15:0] len;
        logic [1:0]  status;
    } t_lookup_result;

    logic [31:0] max_age;
    logic [31:0] budget;
    logic [63:0] tbl_key    [ENTRIES];
    logic [31:0] tbl_handle [ENTRIES];
    logic [15:0] tbl_len    [ENTRIES];
    logic [47:0] tbl_stamp  [ENTRIES];
    int          tbl_count;
    int          cursor;
    logic [31:0] bytes_total;
    t_lookup_result expected_results[$];

    function automatic logic is_below(logic [63:0] a, logic [63:0] b);
        return (a ^ 64'h8000_0000_0000_0000) < (b ^ 64'h8000_0000_0000_0000);
    endfunction

    function automatic logic is_live(int i, logic [47:0] now);
        return 64'(tbl_stamp[i]) + 64'(max_age) >= 64'(now);
    endfunction

    function automatic int find_slot(logic [63:0] k);
        int i;
        i = 0;
        while (i < tbl_count && is_below(tbl_key[i], k))
            i++;
        return i;
    endfunction

    task automatic drop_entry(int i);
        bytes_total = bytes_total - 32'(tbl_len[i]);
        for (int j = i; j < tbl_count - 1; j++) begin
            tbl_key[j]    = tbl_key[j + 1];
            tbl_handle[j] = tbl_handle[j + 1];
            tbl_len[j]    = tbl_len[j + 1];
            tbl_stamp[j]  = tbl_stamp[j + 1];
        end
        tbl_count--;
        if (cursor > i)
            cursor--;
    endtask

    task automatic advance_sweep(logic [47:0] now, logic forced);
        if (cursor >= tbl_count) begin
            cursor = 0;
        end else if (forced || !is_live(cursor, now)) begin
            drop_entry(cursor);
        end else begin
            cursor++;
        end
    endtask

    task automatic predict_request(logic [1:0] f, logic [63:0] k, logic [31:0] h,
                                   logic [15:0] l, logic [47:0] now);
        t_lookup_result r;
        int p;
        r = '{1'b0, 32'd0, 16'd0, ST_DONE};
        if (f == FN_INSERT) begin
            advance_sweep(now, 1'b0);
            if (max_age == 0 || budget == 0) begin
                r.status = ST_DISABLED;
            end else begin
                p = find_slot(k);
                if (p < tbl_count && tbl_key[p] == k)
                    drop_entry(p);
                if (tbl_count >= ENTRIES) begin
                    r.status = ST_FULL;
                end else begin
                    for (int j = tbl_count; j > p; j--) begin
                        tbl_key[j]    = tbl_key[j - 1];
                        tbl_handle[j] = tbl_handle[j - 1];
                        tbl_len[j]    = tbl_len[j - 1];
                        tbl_stamp[j]  = tbl_stamp[j - 1];
                    end
                    tbl_key[p]    = k;
                    tbl_handle[p] = h;
                    tbl_len[p]    = l;
                    tbl_stamp[p]  = now;
                    tbl_count++;
                    if (cursor >= p)
                        cursor++;
                    bytes_total = bytes_total + 32'(l);
                    if (bytes_total > budget)
                        advance_sweep(now, 1'b1);
                end
            end
        end else if (f == FN_LOOKUP) begin
            advance_sweep(now, 1'b0);
            p = find_slot(k);
            if (p < tbl_count && tbl_key[p] == k && is_live(p, now)) begin
                r.hit    = 1'b1;
                r.handle = tbl_handle[p];
                r.len    = tbl_len[p];
            end
        end else if (f == FN_CLEAR) begin
            tbl_count   = 0;
            cursor      = 0;
            bytes_total = 0;
        end
        expected_results.push_back(r);
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_lookup_result want;
        if (!i_rst_n) begin
            max_age      = 32'd1000;
            budget       = 32'd1000000;
            tbl_count    = 0;
            cursor       = 0;
            bytes_total  = 0;
            o_fail_count = 0;
            expected_results.delete();
        end else begin
            if (i_done) begin
                if (expected_results.size() == 0) begin
                    report_mismatch("unexpected result", 64'(i_status), 64'd0);
                end else begin
                    want = expected_results.pop_front();
                    if (i_hit !== want.hit)
                        report_mismatch("hit", 64'(i_hit), 64'(want.hit));
                    if (i_found_handle !== want.handle)
                        report_mismatch("found_handle", 64'(i_found_handle), 64'(want.handle));
                    if (i_found_len !== want.len)
                        report_mismatch("found_len", 64'(i_found_len), 64'(want.len));
                    if (i_status !== want.status)
                        report_mismatch("status", 64'(i_status), 64'(want.status));
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                if (i_cfg_index == REG_MAX_AGE)
                    max_age = i_cfg_data;
                else if (i_cfg_index == REG_BUDGET)
                    budget = i_cfg_data;
            end
            if (i_start && !i_busy)
                predict_request(i_func, i_key, i_handle, i_len, i_now);
        end
        o_pending = expected_results.size();
    end
endmodule

### bench/tb_ttl_keyed_cache_with_sweep_unit.sv
// Testbench top for the keyed TTL cache: clock, reset, directed and random requests,
// register writes between phases and the verdict. Depends on ttlc_pkg,
// ttl_keyed_cache_with_sweep_unit and ttlc_checker.
`timescale 1ns / 1ps
module tb_ttl_keyed_cache_with_sweep_unit;
    import ttlc_pkg::*;

    localparam int STALL_LIMIT = 20000;

    logic        clk;
    logic        rst_n;
    logic        start;
    logic        busy;
    logic [1:0]  func;
    logic [63:0] key;
    logic [31:0] handle;
    logic [15:0] len;
    logic [47:0] now_ms;
    logic        done;
    logic        hit;
    logic [31:0] found_handle;
    logic [15:0] found_len;
    logic [1:0]  status;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    int          fail_count;
    int          pending;
    int          stall_cycles;
    logic        gaps_on;
    logic [63:0] key_pool[32];
    logic [47:0] clock_ms;

    ttl_keyed_cache_with_sweep_unit i_dut (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .o_busy(busy),
        .i_func(func), .i_key(key), .i_payload_handle(handle),
        .i_payload_len(len), .i_now_ms(now_ms),
        .o_done(done), .o_hit(hit), .o_found_handle(found_handle),
        .o_found_len(found_len), .o_status(status),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    ttlc_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n), .i_start(start), .i_busy(busy),
        .i_func(func), .i_key(key), .i_handle(handle), .i_len(len), .i_now(now_ms),
        .i_done(done), .i_hit(hit), .i_found_handle(found_handle),
        .i_found_len(found_len), .i_status(status),
        .i_cfg_valid(cfg_valid), .i_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_fail_count(fail_count), .o_pending(pending)
    );

    initial clk = 1'b0;
    always #5 clk = ~clk;

    always @(posedge clk) begin
        if ((start && !busy) || done || (cfg_valid && cfg_ready) || !rst_n)
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic send(t_func f, logic [63:0] k, logic [31:0] h, logic [15:0] l,
                        logic [47:0] t);
        logic accepted;
        if (gaps_on) begin
            while ($urandom_range(0, 99) < 28) begin
                start = 1'b0;
                @(negedge clk);
            end
        end
        start  = 1'b1;
        func   = f;
        key    = k;
        handle = h;
        len    = l;
        now_ms = t;
        do begin
            @(posedge clk);
            accepted = !busy;
        end while (!accepted);
        @(negedge clk);
    endtask

    task automatic wait_idle();
        start = 1'b0;
        while (pending != 0 || busy)
            @(negedge clk);
    endtask

    task automatic write_reg(t_reg idx, logic [31:0] value);
        logic accepted;
        wait_idle();
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do begin
            @(posedge clk);
            accepted = cfg_ready;
        end while (!accepted);
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    function automatic t_func pick_func();
        int r;
        r = $urandom_range(0, 99);
        if (r < 48)
            return FN_INSERT;
        else if (r < 95)
            return FN_LOOKUP;
        else if (r < 97)
            return FN_CLEAR;
        return FN_NONE;
    endfunction

    task automatic pooled_requests(int count, int step_max, int len_max);
        for (int i = 0; i < count; i++) begin
            clock_ms = clock_ms + 48'($urandom_range(0, step_max));
            send(pick_func(), key_pool[$urandom_range(0, 31)], $urandom,
                 16'($urandom_range(0, len_max)), clock_ms);
        end
    endtask

    initial begin
        rst_n     = 1'b0;
        start     = 1'b0;
        func      = FN_NONE;
        key       = '0;
        handle    = '0;
        len       = '0;
        now_ms    = '0;
        cfg_valid = 1'b0;
        cfg_index = REG_MAX_AGE;
        cfg_data  = '0;
        gaps_on   = 1'b1;
        clock_ms  = 48'd100;
        for (int i = 0; i < 32; i++)
            key_pool[i] = (i < 4) ? {i[1], 63'(i)} : rand64();
        key_pool[4] = 64'h8000_0000_0000_0000;
        key_pool[5] = 64'h7FFF_FFFF_FFFF_FFFF;
        key_pool[6] = 64'hFFFF_FFFF_FFFF_FFFF;
        repeat (5) @(negedge clk);
        rst_n = 1'b1;

        // directed: key extremes, replace, expiry, unused func, clear, disabled inserts, budget eviction
        send(FN_INSERT, 64'h8000_0000_0000_0000, 32'hFFFF_FFFF, 16'hFFFF, 48'd0);
        send(FN_INSERT, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 16'd0, 48'd10);
        send(FN_INSERT, 64'd0, 32'h1234_5678, 16'd77, 48'd20);
        send(FN_LOOKUP, 64'h8000_0000_0000_0000, 32'd0, 16'd0, 48'd1000);
        send(FN_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 16'd0, 48'd1010);
        send(FN_LOOKUP, 64'hFFFF_FFFF_FFFF_FFFF, 32'd0, 16'd0, 48'd1010);
        send(FN_INSERT, 64'h8000_0000_0000_0000, 32'hA5A5_0001, 16'd9, 48'd1011);
        send(FN_LOOKUP, 64'h8000_0000_0000_0000, 32'd0, 16'd0, 48'd1011);
        send(FN_NONE, 64'd0, 32'hFFFF_FFFF, 16'hFFFF, 48'hFFFF_FFFF_FFFF);
        send(FN_LOOKUP, 64'd0, 32'd0, 16'd0, 48'd1021);
        send(FN_LOOKUP, 64'd0, 32'd0, 16'd0, 48'd5000);
        send(FN_LOOKUP, 64'h7FFF_FFFF_FFFF_FFFF, 32'd0, 16'd0, 48'd5000);
        send(FN_CLEAR, 64'd0, 32'd0, 16'd0, 48'd5000);
        send(FN_LOOKUP, 64'h8000_0000_0000_0000, 32'd0, 16'd0, 48'd5000);
        write_reg(REG_MAX_AGE, 32'd0);
        send(FN_INSERT, 64'd5, 32'd1, 16'd1, 48'd6000);
        send(FN_LOOKUP, 64'd5, 32'd0, 16'd0, 48'd6000);
        write_reg(REG_MAX_AGE, 32'd1000);
        write_reg(REG_BUDGET, 32'd0);
        send(FN_INSERT, 64'd6, 32'd2, 16'd2, 48'd6000);
        write_reg(REG_BUDGET, 32'd1);
        send(FN_INSERT, 64'd7, 32'd3, 16'd0, 48'd6001);
        send(FN_INSERT, 64'd8, 32'd4, 16'd5, 48'd6002);
        send(FN_LOOKUP, 64'd7, 32'd0, 16'd0, 48'd6003);

        // fill to capacity without gaps, then overflow
        write_reg(REG_MAX_AGE, 32'hFFFF_FFFF);
        write_reg(REG_BUDGET, 32'hFFFF_FFFF);
        send(FN_CLEAR, 64'd0, 32'd0, 16'd0, 48'd0);
        gaps_on = 1'b0;
        for (int i = 0; i < 262; i++)
            send(FN_INSERT, rand64(), $urandom, 16'hFFFF, 48'($urandom_range(0, 1000)));
        gaps_on = 1'b1;
        for (int i = 0; i < 30; i++)
            send($urandom_range(0, 1) ? FN_INSERT : FN_LOOKUP, key_pool[$urandom_range(0, 31)],
                 $urandom, 16'($urandom), 48'(i));
        send(FN_CLEAR, 64'd0, 32'd0, 16'd0, 48'd0);

        // short lifetime, frequent expiry
        write_reg(REG_MAX_AGE, 32'd60);
        write_reg(REG_BUDGET, 32'd1000000);
        pooled_requests(300, 40, 2000);

        // tight byte budget, frequent eviction
        write_reg(REG_MAX_AGE, 32'd1000);
        write_reg(REG_BUDGET, 32'd3000);
        pooled_requests(180, 20, 1500);

        // full-range fields and times
        write_reg(REG_MAX_AGE, $urandom);
        write_reg(REG_BUDGET, $urandom);
        for (int i = 0; i < 150; i++) begin
            clock_ms = {$urandom, 16'($urandom)};
            send(pick_func(), $urandom_range(0, 1) ? rand64() : key_pool[$urandom_range(0, 31)],
                 $urandom, 16'($urandom), clock_ms);
        end

        wait_idle();
        repeat (600) @(negedge clk);
        if (fail_count == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end
endmodule
